>>> rtl/core/idb_pkg.sv
// ============================================================================
// idb_pkg
// Shared types and constants for the indexed deque buffer.
// ============================================================================
package idb_pkg;

    localparam int DEPTH      = 256;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = ADDR_W + 1;

    localparam int OPCODE_W = 4;
    localparam int POS_W    = 9;
    localparam int ENDP_W   = 8;
    localparam int VALUE_W  = 32;
    localparam int LENGTH_W = 9;
    localparam int PUSHED_W = 8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_BACK  = 4'd0,
        OP_PUSH_FRONT = 4'd1,
        OP_POP_FRONT  = 4'd2,
        OP_POP_BACK   = 4'd3,
        OP_PEEK_FRONT = 4'd4,
        OP_PEEK_BACK  = 4'd5,
        OP_READ       = 4'd6,
        OP_WRITE      = 4'd7,
        OP_ERASE      = 4'd8,
        OP_TRUNCATE   = 4'd9
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_OOB   = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [POS_W-1:0]    position;
        logic [ENDP_W-1:0]   end_position;
        logic [VALUE_W-1:0]  value;
    } req_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  data;
        logic [LENGTH_W-1:0] length;
        logic [PUSHED_W-1:0] pushed_index;
        status_t             status;
    } rsp_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic er_rd;
        logic er_wr;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic erase_start;
        logic erase_more;
        logic out_free;
    } stat_t;

endpackage

>>> rtl/core/idb_datapath.sv
// ============================================================================
// idb_datapath
// Ring storage, head and occupancy registers, erase walk and response register.
// ============================================================================
module idb_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  idb_pkg::req_t     req,
    input  idb_pkg::cmd_t     cmd,
    output idb_pkg::stat_t    stat,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output idb_pkg::rsp_t     rsp
);

    logic [idb_pkg::DATA_WIDTH-1:0] mem [idb_pkg::DEPTH];
    logic [idb_pkg::DATA_WIDTH-1:0] rdata_reg;

    idb_pkg::req_t              req_reg;
    logic [idb_pkg::ADDR_W-1:0] head_reg, head_next;
    logic [idb_pkg::CNT_W-1:0]  occ_reg, occ_next;
    idb_pkg::status_t           status_reg, status_next;
    logic [idb_pkg::PUSHED_W-1:0] pushed_reg, pushed_next;
    logic                       use_rd_reg, use_rd_next;
    logic [idb_pkg::CNT_W-1:0]  src_reg, limit_reg;
    logic [idb_pkg::ADDR_W-1:0] dst_reg;
    idb_pkg::rsp_t              rsp_reg;
    logic                       rsp_valid_reg;

    logic                       x_wr, x_rd;
    logic [idb_pkg::ADDR_W-1:0] x_addr;
    logic                       wr_en, rd_en;
    logic [idb_pkg::ADDR_W-1:0] wr_addr, rd_addr;
    logic [idb_pkg::DATA_WIDTH-1:0] wr_data;

    logic                       full, empty;
    logic [idb_pkg::CNT_W-1:0]  pos_c, endp_c, occ_m1, src_start, removed;
    logic                       erase_ok;

    assign full      = (occ_reg == idb_pkg::CNT_W'(idb_pkg::DEPTH));
    assign empty     = (occ_reg == '0);
    assign pos_c     = idb_pkg::CNT_W'(req_reg.position);
    assign endp_c    = idb_pkg::CNT_W'(req_reg.end_position);
    assign occ_m1    = occ_reg - idb_pkg::CNT_W'(1);
    assign src_start = endp_c + idb_pkg::CNT_W'(1);
    assign removed   = endp_c - pos_c + idb_pkg::CNT_W'(1);
    assign erase_ok  = (pos_c <= endp_c) && (endp_c < occ_reg);

    always_comb
    begin
        head_next   = head_reg;
        occ_next    = occ_reg;
        status_next = idb_pkg::ST_OK;
        pushed_next = '0;
        use_rd_next = 1'b0;
        x_wr        = 1'b0;
        x_rd        = 1'b0;
        x_addr      = head_reg;
        unique case (req_reg.opcode) inside
            idb_pkg::OP_PUSH_BACK:
            begin
                if (full)
                begin
                    status_next = idb_pkg::ST_FULL;
                end
                else
                begin
                    x_wr        = 1'b1;
                    x_addr      = head_reg + occ_reg[idb_pkg::ADDR_W-1:0];
                    pushed_next = idb_pkg::PUSHED_W'(occ_reg[idb_pkg::ADDR_W-1:0]);
                    occ_next    = occ_reg + idb_pkg::CNT_W'(1);
                end
            end
            idb_pkg::OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_next = idb_pkg::ST_FULL;
                end
                else
                begin
                    x_wr      = 1'b1;
                    x_addr    = head_reg - idb_pkg::ADDR_W'(1);
                    head_next = head_reg - idb_pkg::ADDR_W'(1);
                    occ_next  = occ_reg + idb_pkg::CNT_W'(1);
                end
            end
            idb_pkg::OP_POP_FRONT, idb_pkg::OP_PEEK_FRONT:
            begin
                if (empty)
                begin
                    status_next = idb_pkg::ST_EMPTY;
                end
                else
                begin
                    x_rd        = 1'b1;
                    use_rd_next = 1'b1;
                    x_addr      = head_reg;
                    if (req_reg.opcode == idb_pkg::OP_POP_FRONT)
                    begin
                        head_next = head_reg + idb_pkg::ADDR_W'(1);
                        occ_next  = occ_m1;
                    end
                end
            end
            idb_pkg::OP_POP_BACK, idb_pkg::OP_PEEK_BACK:
            begin
                if (empty)
                begin
                    status_next = idb_pkg::ST_EMPTY;
                end
                else
                begin
                    x_rd        = 1'b1;
                    use_rd_next = 1'b1;
                    x_addr      = head_reg + occ_m1[idb_pkg::ADDR_W-1:0];
                    if (req_reg.opcode == idb_pkg::OP_POP_BACK)
                    begin
                        occ_next = occ_m1;
                    end
                end
            end
            idb_pkg::OP_READ, idb_pkg::OP_WRITE:
            begin
                if (pos_c >= occ_reg)
                begin
                    status_next = idb_pkg::ST_OOB;
                end
                else
                begin
                    x_addr = head_reg + req_reg.position[idb_pkg::ADDR_W-1:0];
                    if (req_reg.opcode == idb_pkg::OP_READ)
                    begin
                        x_rd        = 1'b1;
                        use_rd_next = 1'b1;
                    end
                    else
                    begin
                        x_wr = 1'b1;
                    end
                end
            end
            idb_pkg::OP_ERASE:
            begin
                if (!erase_ok)
                begin
                    status_next = idb_pkg::ST_OOB;
                end
                else
                begin
                    occ_next = occ_reg - removed;
                end
            end
            idb_pkg::OP_TRUNCATE:
            begin
                if (pos_c > occ_reg)
                begin
                    status_next = idb_pkg::ST_OOB;
                end
                else
                begin
                    occ_next = pos_c;
                end
            end
            default:
            begin
                status_next = idb_pkg::ST_OOB;
            end
        endcase
    end

    assign stat.erase_start = (req_reg.opcode == idb_pkg::OP_ERASE) && erase_ok
                              && (src_start != occ_reg);
    assign stat.erase_more  = (src_reg + idb_pkg::CNT_W'(1)) != limit_reg;
    assign stat.out_free    = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        wr_en   = (cmd.exec && x_wr) || cmd.er_wr;
        wr_addr = cmd.er_wr ? (head_reg + dst_reg) : x_addr;
        wr_data = cmd.er_wr ? rdata_reg : req_reg.value[idb_pkg::DATA_WIDTH-1:0];
        rd_en   = (cmd.exec && x_rd) || cmd.er_rd;
        rd_addr = cmd.er_rd ? (head_reg + src_reg[idb_pkg::ADDR_W-1:0]) : x_addr;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
            pushed_reg <= pushed_next;
            use_rd_reg <= use_rd_next;
            src_reg    <= src_start;
            dst_reg    <= req_reg.position[idb_pkg::ADDR_W-1:0];
            limit_reg  <= occ_reg;
        end
        else if (cmd.er_wr)
        begin
            src_reg <= src_reg + idb_pkg::CNT_W'(1);
            dst_reg <= dst_reg + idb_pkg::ADDR_W'(1);
        end
        if (cmd.load_out)
        begin
            rsp_reg.data         <= use_rd_reg ? idb_pkg::VALUE_W'(rdata_reg) : '0;
            rsp_reg.length       <= idb_pkg::LENGTH_W'(occ_reg);
            rsp_reg.pushed_index <= pushed_reg;
            rsp_reg.status       <= status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            occ_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                head_reg <= head_next;
                occ_reg  <= occ_next;
            end
            if (cmd.load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef NO_ASSERTIONS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= idb_pkg::CNT_W'(idb_pkg::DEPTH))
        else $error("occupancy exceeds depth");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> stat.out_free)
        else $error("response loaded over an unaccepted response");
    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.er_wr |-> (src_reg < limit_reg))
        else $error("erase walk ran past the old tail");
    a_occ_exec: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(cmd.exec) |-> $stable(occ_reg))
        else $error("occupancy changed outside execution");
`endif

endmodule

>>> rtl/core/idb_ctrl.sv
// ============================================================================
// idb_ctrl
// Sequencer for request capture, execution, erase walk and response load.
// ============================================================================
module idb_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  idb_pkg::stat_t  stat,
    output idb_pkg::cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ER_RD,
        S_ER_WR,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        req_ready    = (state_reg == S_IDLE) || ((state_reg == S_DONE) && stat.out_free);
        cmd.capture  = req_valid && req_ready;
        cmd.exec     = (state_reg == S_EXEC);
        cmd.er_rd    = (state_reg == S_ER_RD);
        cmd.er_wr    = (state_reg == S_ER_WR);
        cmd.load_out = (state_reg == S_DONE) && stat.out_free;
        state_next   = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = stat.erase_start ? S_ER_RD : S_DONE;
            end
            S_ER_RD:
            begin
                state_next = S_ER_WR;
            end
            S_ER_WR:
            begin
                state_next = stat.erase_more ? S_ER_RD : S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = req_valid ? S_EXEC : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_exec_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> cmd.exec)
        else $error("captured request not executed");
    a_rd_then_wr: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.er_rd |=> cmd.er_wr)
        else $error("erase read not followed by write");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.exec, cmd.er_rd, cmd.er_wr, cmd.load_out}))
        else $error("conflicting datapath commands");
`endif

endmodule

>>> rtl/core/indexed_deque_buffer_top.sv
// ============================================================================
// indexed_deque_buffer_top
// Double-ended queue of data words with indexed access, held in a ring buffer.
// ============================================================================
//   Channel   Direction  Handshake              Payload
//   request   in         req_valid / req_ready  req (idb_pkg::req_t)
//   response  out        rsp_valid / rsp_ready  rsp (idb_pkg::rsp_t)
//
// A request is captured, then executed with one access of the ring memory,
// and the response is registered in the final state once the output is free.
// An erase adds a read and a write state per word moved down from behind the range.
// Reset clears the head, the count and the response valid; no clearing pass.
// A stalled response holds the sequencer in its final state, and the next
// request is taken in the same cycle that the held response leaves.
module indexed_deque_buffer_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  idb_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output idb_pkg::rsp_t  rsp
);

    idb_pkg::cmd_t  cmd;
    idb_pkg::stat_t stat;

    idb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    idb_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

>>> dv/tb.sv
// ============================================================================
// tb
// Self-checking bench for the indexed deque buffer. A queue of requests feeds
// a clocked driver, each accepted request is run through a local deque model,
// and a clocked monitor compares every response field with the oldest
// prediction while both sides idle at random.
// ============================================================================
module tb;

    localparam logic [idb_pkg::OPCODE_W-1:0] OP_SPARE_FIRST =
        idb_pkg::OPCODE_W'(idb_pkg::OP_TRUNCATE + 1);
    localparam logic [idb_pkg::OPCODE_W-1:0] OP_SPARE_LAST  = '1;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 400;

    logic clk;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    idb_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    idb_pkg::rsp_t rsp;

    idb_pkg::req_t pending_reqs[$];
    idb_pkg::rsp_t expected_rsps[$];

    logic [idb_pkg::DATA_WIDTH-1:0] ring_mem [idb_pkg::DEPTH];
    logic [idb_pkg::ADDR_W-1:0]     ring_head = '0;
    int                             ring_count = 0;

    int plan_len = 0;
    int idle_pct = 25;
    int reqs_taken = 0;
    int fail_count = 0;
    int hold_left = 0;
    bit hold_started = 1'b0;

    indexed_deque_buffer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [idb_pkg::ADDR_W-1:0] ring_addr(int idx);
        return idb_pkg::ADDR_W'(int'(ring_head) + idx);
    endfunction

    function automatic idb_pkg::rsp_t deque_step(idb_pkg::req_t r);
        idb_pkg::rsp_t o;
        int pos;
        int last;
        o = '0;
        o.status = idb_pkg::ST_OK;
        pos = int'(r.position);
        last = int'(r.end_position);
        case (r.opcode) inside
            idb_pkg::OP_PUSH_BACK:
                if (ring_count == idb_pkg::DEPTH)
                    o.status = idb_pkg::ST_FULL;
                else
                begin
                    ring_mem[ring_addr(ring_count)] = r.value;
                    o.pushed_index = idb_pkg::PUSHED_W'(ring_count);
                    ring_count++;
                end
            idb_pkg::OP_PUSH_FRONT:
                if (ring_count == idb_pkg::DEPTH)
                    o.status = idb_pkg::ST_FULL;
                else
                begin
                    ring_head = ring_head - idb_pkg::ADDR_W'(1);
                    ring_mem[ring_head] = r.value;
                    ring_count++;
                end
            idb_pkg::OP_POP_FRONT, idb_pkg::OP_POP_BACK,
            idb_pkg::OP_PEEK_FRONT, idb_pkg::OP_PEEK_BACK:
                if (ring_count == 0)
                    o.status = idb_pkg::ST_EMPTY;
                else if (r.opcode == idb_pkg::OP_POP_FRONT
                         || r.opcode == idb_pkg::OP_PEEK_FRONT)
                begin
                    o.data = ring_mem[ring_head];
                    if (r.opcode == idb_pkg::OP_POP_FRONT)
                    begin
                        ring_head = ring_head + idb_pkg::ADDR_W'(1);
                        ring_count--;
                    end
                end
                else
                begin
                    o.data = ring_mem[ring_addr(ring_count - 1)];
                    if (r.opcode == idb_pkg::OP_POP_BACK)
                        ring_count--;
                end
            idb_pkg::OP_READ:
                if (pos >= ring_count)
                    o.status = idb_pkg::ST_OOB;
                else
                    o.data = ring_mem[ring_addr(pos)];
            idb_pkg::OP_WRITE:
                if (pos >= ring_count)
                    o.status = idb_pkg::ST_OOB;
                else
                    ring_mem[ring_addr(pos)] = r.value;
            idb_pkg::OP_ERASE:
                if (pos > last || last >= ring_count)
                    o.status = idb_pkg::ST_OOB;
                else
                begin
                    for (int i = last + 1; i < ring_count; i++)
                        ring_mem[ring_addr(pos + i - last - 1)] = ring_mem[ring_addr(i)];
                    ring_count -= last - pos + 1;
                end
            idb_pkg::OP_TRUNCATE:
                if (pos > ring_count)
                    o.status = idb_pkg::ST_OOB;
                else
                    ring_count = pos;
            default:
                o.status = idb_pkg::ST_OOB;
        endcase
        o.length = idb_pkg::LENGTH_W'(ring_count);
        return o;
    endfunction

    function automatic bit field_ok(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $error("response field %s: expected %0h, got %0h", name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic offer(logic [idb_pkg::OPCODE_W-1:0] op, int pos, int last,
                         logic [idb_pkg::VALUE_W-1:0] val);
        idb_pkg::req_t r;
        r.opcode = op;
        r.position = idb_pkg::POS_W'(pos);
        r.end_position = idb_pkg::ENDP_W'(last);
        r.value = val;
        pending_reqs.push_back(r);
        case (op) inside
            idb_pkg::OP_PUSH_BACK, idb_pkg::OP_PUSH_FRONT:
                if (plan_len < idb_pkg::DEPTH)
                    plan_len++;
            idb_pkg::OP_POP_FRONT, idb_pkg::OP_POP_BACK:
                if (plan_len > 0)
                    plan_len--;
            idb_pkg::OP_ERASE:
                if (r.position <= r.end_position && r.end_position < plan_len)
                    plan_len -= int'(r.end_position) - int'(r.position) + 1;
            idb_pkg::OP_TRUNCATE:
                if (r.position <= plan_len)
                    plan_len = int'(r.position);
            default:
                ;
        endcase
    endtask

    task automatic offer_random(int push_pct);
        int kind;
        int len;
        int pos;
        int last;
        logic [idb_pkg::OPCODE_W-1:0] op;
        len = plan_len;
        pos = $urandom_range(len);
        last = pos + $urandom_range(3);
        if ($urandom_range(99) < push_pct)
            kind = 15;
        else
            kind = $urandom_range(15);
        case (kind) inside
            0: op = idb_pkg::OP_POP_FRONT;
            1: op = idb_pkg::OP_POP_BACK;
            2: op = idb_pkg::OP_PEEK_FRONT;
            3: op = idb_pkg::OP_PEEK_BACK;
            4, 5: op = idb_pkg::OP_READ;
            6, 7: op = idb_pkg::OP_WRITE;
            8, 9, 10:
            begin
                op = idb_pkg::OP_ERASE;
                pos = (len == 0) ? 0 : $urandom_range(len - 1);
                last = pos + $urandom_range(3);
            end
            11:
            begin
                op = idb_pkg::OP_TRUNCATE;
                pos = len - $urandom_range((len < 6) ? len : 6);
            end
            12: op = idb_pkg::OPCODE_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
            default: op = $urandom_range(1) ? idb_pkg::OP_PUSH_FRONT : idb_pkg::OP_PUSH_BACK;
        endcase
        if ($urandom_range(15) == 0)
        begin
            pos = $urandom_range((1 << idb_pkg::POS_W) - 1);
            last = $urandom_range((1 << idb_pkg::ENDP_W) - 1);
        end
        offer(op, pos, last, $urandom());
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                expected_rsps.push_back(deque_step(req));
                reqs_taken++;
            end
            if (!req_valid || req_ready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    req <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        idb_pkg::rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("response with no request outstanding: %0h", rsp);
                    fail_count++;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (!field_ok("data", want.data, rsp.data)
                        | !field_ok("length", want.length, rsp.length)
                        | !field_ok("pushed_index", want.pushed_index, rsp.pushed_index)
                        | !field_ok("status", want.status, rsp.status))
                        fail_count++;
                end
            end
            if (!hold_started && reqs_taken >= HOLD_AT)
            begin
                hold_started = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    initial
    begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        offer(idb_pkg::OP_POP_FRONT, 0, 0, '0);
        offer(idb_pkg::OP_POP_BACK, 0, 0, '0);
        offer(idb_pkg::OP_PEEK_FRONT, 0, 0, '0);
        offer(idb_pkg::OP_PEEK_BACK, 0, 0, '0);
        offer(idb_pkg::OP_READ, 0, 0, '0);
        offer(idb_pkg::OP_WRITE, 0, 0, 32'h1234_5678);
        offer(idb_pkg::OP_ERASE, 0, 0, '0);
        offer(idb_pkg::OP_TRUNCATE, 0, 0, '0);
        offer(idb_pkg::OP_TRUNCATE, idb_pkg::DEPTH, 0, '0);
        offer(OP_SPARE_FIRST, 0, 0, '0);
        offer(OP_SPARE_LAST, (1 << idb_pkg::POS_W) - 1, (1 << idb_pkg::ENDP_W) - 1, '1);
        offer(idb_pkg::OP_PUSH_BACK, 0, 0, 32'hFFFF_FFFF);
        offer(idb_pkg::OP_PUSH_FRONT, 0, 0, 32'h0000_0000);
        offer(idb_pkg::OP_PUSH_BACK, 0, 0, 32'hA5A5_A5A5);
        offer(idb_pkg::OP_PUSH_FRONT, 0, 0, 32'h5A5A_5A5A);
        offer(idb_pkg::OP_PEEK_FRONT, 0, 0, '0);
        offer(idb_pkg::OP_PEEK_BACK, 0, 0, '0);
        offer(idb_pkg::OP_READ, 4, 0, '0);
        offer(idb_pkg::OP_READ, 3, 0, '0);
        offer(idb_pkg::OP_WRITE, 3, 0, 32'hDEAD_BEEF);
        offer(idb_pkg::OP_ERASE, 2, 1, '0);
        offer(idb_pkg::OP_ERASE, 1, (1 << idb_pkg::ENDP_W) - 1, '0);
        offer(idb_pkg::OP_ERASE, 1, 2, '0);
        offer(idb_pkg::OP_TRUNCATE, 1, 0, '0);
        offer(idb_pkg::OP_POP_FRONT, 0, 0, '0);
        wait_drained();

        repeat (40) offer_random(30);
        wait_drained();

        // The fill run has no idle cycles; the long response hold-off lands here.
        idle_pct = 0;
        while (plan_len < idb_pkg::DEPTH)
            offer_random(85);
        repeat (3) offer(idb_pkg::OP_PUSH_BACK, 0, 0, $urandom());
        repeat (3) offer(idb_pkg::OP_PUSH_FRONT, 0, 0, $urandom());
        offer(idb_pkg::OP_READ, idb_pkg::DEPTH - 1, 0, '0);
        offer(idb_pkg::OP_TRUNCATE, idb_pkg::DEPTH, 0, '0);
        offer(idb_pkg::OP_POP_BACK, 0, 0, '0);
        offer(idb_pkg::OP_PUSH_BACK, 0, 0, $urandom());
        offer(idb_pkg::OP_ERASE, 0, 0, '0);
        offer(idb_pkg::OP_PEEK_BACK, 0, 0, '0);
        wait_drained();

        idle_pct = 25;
        repeat (80) offer_random(20);
        wait_drained();

        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule

>>> filelist.f
rtl/core/idb_pkg.sv
rtl/core/idb_datapath.sv
rtl/core/idb_ctrl.sv
rtl/core/indexed_deque_buffer_top.sv
dv/tb.sv
